/* design/psovu_pkg.sv */
// Package for the particle swarm velocity update block.
// Holds word formats, register indexes, widths and the saturation helpers.
// Used by psovu_mac and pso_particle_velocity_update; depends on nothing.
`default_nettype none

package psovu_pkg;

    // Number formats
    localparam int VAL_W      = 40;  // signed coordinate width
    localparam int LIM_W      = VAL_W - 1;
    localparam int FRAC_BITS  = 16;
    localparam int WEIGHT_W   = 17;  // inertia and random factors
    localparam int GAIN_W     = 19;
    localparam int CR_W       = 20;  // saturated gain times random factor
    localparam int CHUNK_W    = VAL_W / 2;
    localparam int OP_W       = CHUNK_W + 2;
    localparam int PROD_W     = 2 * OP_W;
    localparam int ACC_W      = VAL_W + CR_W + 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = GAIN_W;

    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INERTIA_STEP   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_COGNITIVE_GAIN = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SOCIAL_GAIN    = 3'd4;

    localparam logic [WEIGHT_W-1:0] INERTIA_START_RST  = 17'd58982;
    localparam logic [WEIGHT_W-1:0] INERTIA_FLOOR_RST  = 17'd26214;
    localparam logic [WEIGHT_W-1:0] INERTIA_STEP_RST   = 17'd655;
    localparam logic [GAIN_W-1:0]   COGNITIVE_GAIN_RST = 19'd131072;
    localparam logic [GAIN_W-1:0]   SOCIAL_GAIN_RST    = 19'd131072;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef struct packed {
        logic signed [VAL_W-1:0] position;
        logic signed [VAL_W-1:0] velocity;
        logic signed [VAL_W-1:0] personal_best;
        logic signed [VAL_W-1:0] swarm_best;
        logic [LIM_W-1:0]        speed_limit;
        logic signed [VAL_W-1:0] lower_bound;
        logic signed [VAL_W-1:0] upper_bound;
        logic [WEIGHT_W-1:0]     rand_one;
        logic [WEIGHT_W-1:0]     rand_two;
        logic                    last_dimension;
    } in_word_t;

    typedef struct packed {
        logic signed [VAL_W-1:0] new_velocity;
        logic signed [VAL_W-1:0] new_position;
        logic                    is_last;
    } out_word_t;

    // Control of the shared multiply-accumulate unit.
    typedef struct packed {
        logic load;    // accumulator takes the product
        logic add_hi;  // accumulator adds the product shifted by one chunk
    } mac_ctl_t;

    function automatic logic signed [VAL_W-1:0] sat_wide(input logic signed [VAL_W:0] a);
        logic signed [VAL_W-1:0] r;
        if (a[VAL_W] != a[VAL_W-1])
            r = a[VAL_W] ? VAL_MIN : VAL_MAX;
        else
            r = a[VAL_W-1:0];
        return r;
    endfunction

    function automatic logic signed [VAL_W-1:0] add_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) + $signed({b[VAL_W-1], b});
        return sat_wide(s);
    endfunction

    function automatic logic signed [VAL_W-1:0] sub_sat(input logic signed [VAL_W-1:0] a,
                                                        input logic signed [VAL_W-1:0] b);
        logic signed [VAL_W:0] s;
        s = $signed({a[VAL_W-1], a}) - $signed({b[VAL_W-1], b});
        return sat_wide(s);
    endfunction

    // Drop the fraction bits of a product (floor) and saturate to a coordinate.
    function automatic logic signed [VAL_W-1:0] term_of(input logic signed [ACC_W-1:0] acc);
        logic signed [ACC_W-1:0] sh;
        logic signed [VAL_W-1:0] r;
        sh = acc >>> FRAC_BITS;
        if (sh[ACC_W-1:VAL_W-1] == '0 || sh[ACC_W-1:VAL_W-1] == '1)
            r = sh[VAL_W-1:0];
        else
            r = sh[ACC_W-1] ? VAL_MIN : VAL_MAX;
        return r;
    endfunction

endpackage

`default_nettype wire

/* design/psovu_mac.sv */
// Shared signed multiplier with a wide accumulator for the velocity update.
// Builds a full product from two chunk products, the upper one added shifted by one chunk.
// Depends on psovu_pkg.
`default_nettype none

module psovu_mac (
    input  wire logic                              clk,
    input  wire psovu_pkg::mac_ctl_t               ctl,
    input  wire logic signed [psovu_pkg::OP_W-1:0] op_a,
    input  wire logic signed [psovu_pkg::OP_W-1:0] op_b,
    output logic signed [psovu_pkg::ACC_W-1:0]     acc
);

    logic signed [psovu_pkg::PROD_W-1:0] prod;
    logic signed [psovu_pkg::ACC_W-1:0]  prod_ext;
    logic signed [psovu_pkg::ACC_W-1:0]  acc_reg;
    logic signed [psovu_pkg::ACC_W-1:0]  acc_next;

    assign prod     = op_a * op_b;
    assign prod_ext = psovu_pkg::ACC_W'(prod);

    always_comb
    begin
        acc_next = acc_reg;
        if (ctl.load)
            acc_next = prod_ext;
        else if (ctl.add_hi)
            acc_next = acc_reg + (prod_ext <<< psovu_pkg::CHUNK_W);
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
    end

    assign acc = acc_reg;

endmodule

`default_nettype wire

/* design/pso_particle_velocity_update.sv */
// Top level of the particle swarm velocity and position update block.
// Sequences one shared multiply-accumulate unit (psovu_mac) per word.
// Depends on psovu_pkg and psovu_mac.
//
//   Channel   Handshake             Payload                 Direction
//   in        in_valid / in_ready   in_data  (in_word_t)    into block
//   out       out_valid / out_ready out_data (out_word_t)   out of block
//   cfg       cfg_we                cfg_index, cfg_data     into block
//
// Each word passes through the sequencer steps from acceptance to its result in the
// output register; those from CR1 to DG_HI are passes through the single 22 x 22 multiplier
// (two random-factor scalings and three 40-bit products in two chunks each).
// A new word is accepted in the cycle after the previous one finishes, even
// while that result still waits in the output register.
// The last step waits while the output register holds an untaken word.
// Reset loads the register defaults and sets the inertia to inertia_start.
`default_nettype none

module pso_particle_velocity_update (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  in_valid,
    output logic                                       in_ready,
    input  wire psovu_pkg::in_word_t                   in_data,
    output logic                                       out_valid,
    input  wire logic                                  out_ready,
    output psovu_pkg::out_word_t                       out_data,
    input  wire logic                                  cfg_we,
    input  wire logic [psovu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [psovu_pkg::CFG_DATA_W-1:0]      cfg_data
);

    // Sequencer steps. The multiplier is busy in steps CR1 through DG_HI.
    localparam logic [3:0] STEP_CR1    = 4'd0;   // gain1 * rand1
    localparam logic [3:0] STEP_CR2    = 4'd1;   // gain2 * rand2, first difference
    localparam logic [3:0] STEP_V_LO   = 4'd2;   // inertia * low velocity chunk
    localparam logic [3:0] STEP_V_HI   = 4'd3;
    localparam logic [3:0] STEP_DP_LO  = 4'd4;   // inertia term enters the sum
    localparam logic [3:0] STEP_DP_HI  = 4'd5;
    localparam logic [3:0] STEP_DG_LO  = 4'd6;   // cognitive term enters the sum
    localparam logic [3:0] STEP_DG_HI  = 4'd7;
    localparam logic [3:0] STEP_SUM    = 4'd8;   // social term enters the sum
    localparam logic [3:0] STEP_VCLAMP = 4'd9;
    localparam logic [3:0] STEP_PSUM   = 4'd10;
    localparam logic [3:0] STEP_PCLAMP = 4'd11;

    localparam int VAL_W    = psovu_pkg::VAL_W;
    localparam int OP_W     = psovu_pkg::OP_W;
    localparam int CHUNK_W  = psovu_pkg::CHUNK_W;
    localparam int CR_W     = psovu_pkg::CR_W;
    localparam int WEIGHT_W = psovu_pkg::WEIGHT_W;
    localparam int GAIN_W   = psovu_pkg::GAIN_W;
    localparam int FRAC     = psovu_pkg::FRAC_BITS;
    localparam int ACC_W    = psovu_pkg::ACC_W;

    // Configuration and kept state. The start value is not kept on its own:
    // a write to it goes straight into the inertia.
    logic [WEIGHT_W-1:0] inertia_floor_reg, inertia_step_reg;
    logic [GAIN_W-1:0]   cognitive_gain_reg, social_gain_reg;
    logic [WEIGHT_W-1:0] inertia_reg, inertia_next;

    // Control.
    logic       busy_reg, busy_next;
    logic [3:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;

    // Working registers of the current word.
    psovu_pkg::in_word_t     word_reg;
    logic [CR_W-1:0]         cr1_reg, cr1_next, cr2_reg, cr2_next;
    logic signed [VAL_W-1:0] dp_reg, dp_next, dg_reg, dg_next;
    logic signed [VAL_W-1:0] sum_reg, sum_next;
    logic signed [VAL_W-1:0] pos_reg, pos_next;
    psovu_pkg::out_word_t    out_reg, out_next;

    // Shared unit.
    psovu_pkg::mac_ctl_t     mac_ctl;
    logic signed [OP_W-1:0]  op_a, op_b;
    logic signed [ACC_W-1:0] acc;

    // Other combinational values.
    logic                    in_fire;
    logic                    out_free;
    logic [CR_W-1:0]         cr_sat;
    logic signed [VAL_W-1:0] diff_val;
    logic signed [VAL_W:0]   vel_wide, lim_wide;
    logic signed [VAL_W-1:0] vel_clamped;
    logic signed [VAL_W-1:0] pos_hi, pos_clamped;

    assign in_ready  = !busy_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    psovu_mac u_mac (
        .clk  (clk),
        .ctl  (mac_ctl),
        .op_a (op_a),
        .op_b (op_b),
        .acc  (acc)
    );

    // The scaling product gain * rand is never negative, so any bit above the
    // kept field means saturation.
    always_comb
    begin
        if (|acc[ACC_W-1:FRAC+CR_W])
            cr_sat = '1;
        else
            cr_sat = acc[FRAC+CR_W-1:FRAC];
    end

    // One subtractor forms the personal difference, then the global one.
    assign diff_val = psovu_pkg::sub_sat((step_reg == STEP_CR2) ? word_reg.personal_best
                                                                 : word_reg.swarm_best,
                                         word_reg.position);

    // Velocity clamp to plus or minus the speed limit.
    assign vel_wide = {sum_reg[VAL_W-1], sum_reg};
    assign lim_wide = $signed({2'b00, word_reg.speed_limit});

    always_comb
    begin
        if (vel_wide > lim_wide)
            vel_clamped = lim_wide[VAL_W-1:0];
        else if (vel_wide < -lim_wide)
            vel_clamped = sum_reg - sum_reg - lim_wide[VAL_W-1:0];
        else
            vel_clamped = sum_reg;
    end

    // Position clamp: the upper bound first, then the lower bound, so the
    // lower bound wins when the bounds cross.
    always_comb
    begin
        pos_hi = (pos_reg > word_reg.upper_bound) ? word_reg.upper_bound : pos_reg;
        pos_clamped = (pos_hi < word_reg.lower_bound) ? word_reg.lower_bound : pos_hi;
    end

    // Sequencer. The upper chunk of a coordinate carries its sign, so it is
    // sign-extended into the multiplier; the lower chunk is zero-extended.
    always_comb
    begin
        busy_next      = busy_reg;
        step_next      = step_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        inertia_next   = inertia_reg;
        cr1_next       = cr1_reg;
        cr2_next       = cr2_reg;
        dp_next        = dp_reg;
        dg_next        = dg_reg;
        sum_next       = sum_reg;
        pos_next       = pos_reg;
        mac_ctl        = '0;
        op_a           = '0;
        op_b           = '0;

        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;

        if (in_fire)
        begin
            busy_next = 1'b1;
            step_next = STEP_CR1;
        end

        if (busy_reg)
        begin
            step_next = step_reg + 4'd1;
            unique case (step_reg)
                STEP_CR1:
                begin
                    mac_ctl.load = 1'b1;
                    op_a = $signed(OP_W'(cognitive_gain_reg));
                    op_b = $signed(OP_W'(word_reg.rand_one));
                end
                STEP_CR2:
                begin
                    mac_ctl.load = 1'b1;
                    op_a = $signed(OP_W'(social_gain_reg));
                    op_b = $signed(OP_W'(word_reg.rand_two));
                    cr1_next = cr_sat;
                    dp_next = diff_val;
                end
                STEP_V_LO:
                begin
                    mac_ctl.load = 1'b1;
                    op_a = $signed(OP_W'(inertia_reg));
                    op_b = $signed(OP_W'(word_reg.velocity[CHUNK_W-1:0]));
                    cr2_next = cr_sat;
                    dg_next = diff_val;
                end
                STEP_V_HI:
                begin
                    mac_ctl.add_hi = 1'b1;
                    op_a = $signed(OP_W'(inertia_reg));
                    op_b = OP_W'($signed(word_reg.velocity[VAL_W-1:CHUNK_W]));
                end
                STEP_DP_LO:
                begin
                    mac_ctl.load = 1'b1;
                    op_a = $signed(OP_W'(cr1_reg));
                    op_b = $signed(OP_W'(dp_reg[CHUNK_W-1:0]));
                    sum_next = psovu_pkg::term_of(acc);
                end
                STEP_DP_HI:
                begin
                    mac_ctl.add_hi = 1'b1;
                    op_a = $signed(OP_W'(cr1_reg));
                    op_b = OP_W'($signed(dp_reg[VAL_W-1:CHUNK_W]));
                end
                STEP_DG_LO:
                begin
                    mac_ctl.load = 1'b1;
                    op_a = $signed(OP_W'(cr2_reg));
                    op_b = $signed(OP_W'(dg_reg[CHUNK_W-1:0]));
                    sum_next = psovu_pkg::add_sat(sum_reg, psovu_pkg::term_of(acc));
                end
                STEP_DG_HI:
                begin
                    mac_ctl.add_hi = 1'b1;
                    op_a = $signed(OP_W'(cr2_reg));
                    op_b = OP_W'($signed(dg_reg[VAL_W-1:CHUNK_W]));
                end
                STEP_SUM:
                begin
                    sum_next = psovu_pkg::add_sat(sum_reg, psovu_pkg::term_of(acc));
                end
                STEP_VCLAMP:
                begin
                    sum_next = vel_clamped;
                end
                STEP_PSUM:
                begin
                    pos_next = psovu_pkg::add_sat(word_reg.position, sum_reg);
                end
                STEP_PCLAMP:
                begin
                    if (out_free)
                    begin
                        busy_next = 1'b0;
                        step_next = STEP_CR1;
                        out_valid_next = 1'b1;
                        out_next.new_velocity = sum_reg;
                        out_next.new_position = pos_clamped;
                        out_next.is_last = word_reg.last_dimension;
                        // Inertia decays after the last dimension of a particle while it is above the floor.
                        if (word_reg.last_dimension && inertia_reg > inertia_floor_reg)
                            inertia_next = (inertia_step_reg > inertia_reg) ? '0
                                         : inertia_reg - inertia_step_reg;
                    end
                    else
                    begin
                        step_next = step_reg;
                    end
                end
                default:
                begin
                    busy_next = 1'b0;
                    step_next = STEP_CR1;
                end
            endcase
        end

        // Writing the start value also reloads the inertia at once.
        if (cfg_we && cfg_index == psovu_pkg::REG_INERTIA_START)
            inertia_next = cfg_data[WEIGHT_W-1:0];
    end

    // Control and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg           <= 1'b0;
            step_reg           <= STEP_CR1;
            out_valid_reg      <= 1'b0;
            inertia_reg        <= psovu_pkg::INERTIA_START_RST;
            inertia_floor_reg  <= psovu_pkg::INERTIA_FLOOR_RST;
            inertia_step_reg   <= psovu_pkg::INERTIA_STEP_RST;
            cognitive_gain_reg <= psovu_pkg::COGNITIVE_GAIN_RST;
            social_gain_reg    <= psovu_pkg::SOCIAL_GAIN_RST;
        end
        else
        begin
            busy_reg      <= busy_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
            inertia_reg   <= inertia_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    // The start value only seeds the inertia, loaded above.
                    psovu_pkg::REG_INERTIA_START:  ;
                    psovu_pkg::REG_INERTIA_FLOOR:  inertia_floor_reg  <= cfg_data[WEIGHT_W-1:0];
                    psovu_pkg::REG_INERTIA_STEP:   inertia_step_reg   <= cfg_data[WEIGHT_W-1:0];
                    psovu_pkg::REG_COGNITIVE_GAIN: cognitive_gain_reg <= cfg_data;
                    psovu_pkg::REG_SOCIAL_GAIN:    social_gain_reg    <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
            word_reg <= in_data;
        cr1_reg <= cr1_next;
        cr2_reg <= cr2_next;
        dp_reg  <= dp_next;
        dg_reg  <= dg_next;
        sum_reg <= sum_next;
        pos_reg <= pos_next;
        out_reg <= out_next;
    end

    // A result appears only at the end of the final step.
    a_out_from_last_step: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(busy_reg) && $past(step_reg) == STEP_PCLAMP)
        else $error("result word raised outside the final step");

    // An accepted word starts the sequencer at its first step.
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire |=> busy_reg && step_reg == STEP_CR1)
        else $error("accepted word did not start the sequencer");

    // Without a configuration write the inertia never grows.
    a_inertia_no_growth: assert property (@(posedge clk) disable iff (!rst_n)
        !cfg_we |=> inertia_reg <= $past(inertia_reg))
        else $error("inertia grew without a configuration write");

    // With ordered bounds the delivered position lies within them.
    a_position_in_bounds: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg && step_reg == STEP_PCLAMP && out_free
            && word_reg.lower_bound <= word_reg.upper_bound
        |=> out_reg.new_position >= $past(word_reg.lower_bound)
            && out_reg.new_position <= $past(word_reg.upper_bound))
        else $error("position left its bounds");

endmodule

`default_nettype wire

/* dv/psovu_motion_check.sv */
// Checker for the particle swarm velocity update block: watches the input,
// output and register write ports, predicts each result word and compares.
// Depends on psovu_pkg for the word formats and register indexes.
module psovu_motion_check
    import psovu_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic                  in_ready,
    input  in_word_t              in_data,
    input  logic                  out_valid,
    input  logic                  out_ready,
    input  out_word_t             out_data,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatches,
    output int                    outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_SHOWN = 40;

    typedef logic signed [63:0] wide_t;

    logic [WEIGHT_W-1:0] start_weight;
    logic [WEIGHT_W-1:0] floor_weight;
    logic [WEIGHT_W-1:0] step_weight;
    logic [GAIN_W-1:0]   gain_personal;
    logic [GAIN_W-1:0]   gain_swarm;
    logic [WEIGHT_W-1:0] inertia_now;

    out_word_t expected_motion[$];
    int        fail_count = 0;

    assign mismatches = fail_count;

    function automatic logic signed [VAL_W-1:0] clip(input wide_t a);
        if (a > wide_t'(VAL_MAX))
            return VAL_MAX;
        if (a < wide_t'(VAL_MIN))
            return VAL_MIN;
        return a[VAL_W-1:0];
    endfunction

    // Product of a non-negative weight and a coordinate, fraction dropped toward
    // minus infinity, then saturated.
    function automatic logic signed [VAL_W-1:0] weigh(input wide_t factor,
                                                      input logic signed [VAL_W-1:0] val);
        wide_t prod;
        prod = factor * wide_t'(val);
        return clip(prod >>> FRAC_BITS);
    endfunction

    function automatic logic [CR_W-1:0] gain_times_rand(input logic [GAIN_W-1:0] g,
                                                        input logic [WEIGHT_W-1:0] r);
        logic [GAIN_W+WEIGHT_W-1:0] full;
        full = g * r;
        full = full >> FRAC_BITS;
        return (full > (2**CR_W - 1)) ? '1 : full[CR_W-1:0];
    endfunction

    function automatic out_word_t predict_motion(input in_word_t w);
        out_word_t               r;
        logic signed [VAL_W-1:0] to_own;
        logic signed [VAL_W-1:0] to_swarm;
        logic signed [VAL_W-1:0] vel;
        logic signed [VAL_W-1:0] pos;
        wide_t                   lim;
        to_own   = clip(wide_t'(w.personal_best) - wide_t'(w.position));
        to_swarm = clip(wide_t'(w.swarm_best) - wide_t'(w.position));
        vel = weigh(wide_t'(inertia_now), w.velocity);
        vel = clip(wide_t'(vel)
                   + wide_t'(weigh(wide_t'(gain_times_rand(gain_personal, w.rand_one)), to_own)));
        vel = clip(wide_t'(vel)
                   + wide_t'(weigh(wide_t'(gain_times_rand(gain_swarm, w.rand_two)), to_swarm)));
        lim = wide_t'({1'b0, w.speed_limit});
        if (wide_t'(vel) > lim)
            vel = lim[VAL_W-1:0];
        if (wide_t'(vel) < -lim)
            vel = VAL_W'(-lim);
        pos = clip(wide_t'(w.position) + wide_t'(vel));
        if (pos > w.upper_bound)
            pos = w.upper_bound;
        if (pos < w.lower_bound)
            pos = w.lower_bound;
        r.new_velocity = vel;
        r.new_position = pos;
        r.is_last      = w.last_dimension;
        return r;
    endfunction

    // Only the first MAX_SHOWN mismatches are printed; all of them are counted.
    task automatic report(input string what, input longint got, input longint want);
        fail_count++;
        if (fail_count <= MAX_SHOWN)
            $display("%0t ns: %s mismatch, got %0d expected %0d", $realtime, what, got, want);
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t want;
        if (!rst_n)
        begin
            start_weight  = INERTIA_START_RST;
            floor_weight  = INERTIA_FLOOR_RST;
            step_weight   = INERTIA_STEP_RST;
            gain_personal = COGNITIVE_GAIN_RST;
            gain_swarm    = SOCIAL_GAIN_RST;
            inertia_now   = INERTIA_START_RST;
            expected_motion.delete();
            outstanding <= 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_INERTIA_START:
                    begin
                        start_weight = cfg_data[WEIGHT_W-1:0];
                        inertia_now  = start_weight;
                    end
                    REG_INERTIA_FLOOR:  floor_weight  = cfg_data[WEIGHT_W-1:0];
                    REG_INERTIA_STEP:   step_weight   = cfg_data[WEIGHT_W-1:0];
                    REG_COGNITIVE_GAIN: gain_personal = cfg_data[GAIN_W-1:0];
                    REG_SOCIAL_GAIN:    gain_swarm    = cfg_data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                // The word uses the inertia held before its own decay.
                expected_motion.insert(expected_motion.size(), predict_motion(in_data));
                if (in_data.last_dimension && inertia_now > floor_weight)
                    inertia_now = (step_weight > inertia_now) ? '0 : inertia_now - step_weight;
            end
            if (out_valid && out_ready)
            begin
                if (expected_motion.size() == 0)
                    report("unexpected word", out_data.new_velocity, 0);
                else
                begin
                    want = expected_motion.pop_front();
                    if (out_data.new_velocity !== want.new_velocity)
                        report("new_velocity", out_data.new_velocity, want.new_velocity);
                    if (out_data.new_position !== want.new_position)
                        report("new_position", out_data.new_position, want.new_position);
                    if (out_data.is_last !== want.is_last)
                        report("is_last", out_data.is_last, want.is_last);
                end
            end
            outstanding <= expected_motion.size();
        end
    end

endmodule

/* dv/tb.sv */
// Top of the testbench for pso_particle_velocity_update: clock, reset,
// register writes, word stimulus with random idling, and the final verdict.
// Depends on psovu_pkg, the block itself and psovu_motion_check.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import psovu_pkg::*;

    // Wait after the last result, longer than a word needs inside the block, so that any
    // stray output has time to show.
    localparam int SETTLE_CYCLES = 24;
    // Long enough for the output register and the datapath to both fill up.
    localparam int LONG_HOLD     = 120;
    // No register sits at this index; a write there must change nothing.
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    localparam logic signed [VAL_W-1:0] ONE = 40'sd65536;  // 1.0 in Q23.16

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_word_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_word_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    mismatches;
    int                    outstanding;

    // calm switches off all idling for the final stretch of the run;
    // hold_req asks the receiver for one long hold-off.
    bit calm     = 1'b0;
    bit hold_req = 1'b0;

    pso_particle_velocity_update DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    psovu_motion_check motion_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_data     (in_data),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .out_data    (out_data),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Coordinates are mostly within +/-512.0 so that the clamps are hit some
    // of the time, with full-width values and the extremes mixed in.
    function automatic logic signed [VAL_W-1:0] any_coord();
        logic [63:0] raw;
        longint      near;
        raw  = {$urandom, $urandom};
        near = longint'($urandom_range(0, 32'h3FF_FFFF)) - 64'sh200_0000;
        case ($urandom_range(0, 15))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2, 3:    return raw[VAL_W-1:0];
            default: return near[VAL_W-1:0];
        endcase
    endfunction

    function automatic logic [LIM_W-1:0] any_limit();
        logic [63:0] raw;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 11))
            0:       return '0;
            1:       return '1;
            2, 3:    return raw[LIM_W-1:0];
            default: return LIM_W'($urandom_range(0, 32'h1FF_FFFF));
        endcase
    endfunction

    // Random factors are nominally in [0, 1.0], but the full 17 bits are used too.
    function automatic logic [WEIGHT_W-1:0] any_factor();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return WEIGHT_W'(65536);
            2:       return WEIGHT_W'($urandom_range(0, 131071));
            default: return WEIGHT_W'($urandom_range(0, 65536));
        endcase
    endfunction

    // One dimension of a particle. Most words carry sane bounds around the
    // origin; a few carry arbitrary bounds (often crossed) or a stray last flag.
    function automatic in_word_t any_dimension(input logic last);
        in_word_t w;
        w.position       = any_coord();
        w.velocity       = any_coord();
        w.personal_best  = any_coord();
        w.swarm_best     = any_coord();
        w.speed_limit    = any_limit();
        w.rand_one       = any_factor();
        w.rand_two       = any_factor();
        w.last_dimension = last;
        if ($urandom_range(0, 9) == 0)
        begin
            w.lower_bound = any_coord();
            w.upper_bound = any_coord();
        end
        else
        begin
            w.lower_bound = -VAL_W'($urandom_range(0, 32'h1FF_FFFF));
            w.upper_bound = VAL_W'($urandom_range(0, 32'h1FF_FFFF));
        end
        if ($urandom_range(0, 9) == 0)
            w.last_dimension = 1'($urandom_range(0, 1));
        return w;
    endfunction

    // Offers one word and returns at the edge where it is taken. Valid stays
    // high afterwards; it is only lowered at the start of a gap or a pause.
    task automatic send_word(input in_word_t w);
        int gap;
        gap = $urandom_range(1, 6);
        if (!calm && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= w;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic send_fields(input logic signed [VAL_W-1:0] x,
                               input logic signed [VAL_W-1:0] v,
                               input logic signed [VAL_W-1:0] pb,
                               input logic signed [VAL_W-1:0] gb,
                               input logic [LIM_W-1:0]        lim,
                               input logic signed [VAL_W-1:0] lo,
                               input logic signed [VAL_W-1:0] hi,
                               input logic [WEIGHT_W-1:0]     r1,
                               input logic [WEIGHT_W-1:0]     r2,
                               input logic                    last);
        in_word_t w;
        w.position       = x;
        w.velocity       = v;
        w.personal_best  = pb;
        w.swarm_best     = gb;
        w.speed_limit    = lim;
        w.lower_bound    = lo;
        w.upper_bound    = hi;
        w.rand_one       = r1;
        w.rand_two       = r2;
        w.last_dimension = last;
        send_word(w);
    endtask

    // Register writes go out on consecutive cycles; end_writes drops the enable.
    task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
    endtask

    // Pause the sender until every predicted word has come out. Every word
    // yields exactly one result, so the block is idle once the count is zero.
    // The first edge lets the checker see the word taken at this one.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    // Random particles of one to six dimensions, the last one flagged.
    task automatic run_swarm(input int words, input bit squeeze);
        int sent;
        int dims;
        sent = 0;
        if (squeeze)
            hold_req = 1'b1;
        while (sent < words)
        begin
            dims = $urandom_range(1, 6);
            for (int d = 0; d < dims; d++)
            begin
                send_word(any_dimension(d == dims - 1));
                sent++;
            end
        end
        drain();
    endtask

    // Receiver: short random stalls, plus one long hold-off whenever the
    // stimulus asks for it. The hold-off is counted here, in cycles, while
    // the sender keeps offering words so that the block backs up to its input.
    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD - 1) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (!calm && $urandom_range(0, 6) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    initial
    begin
        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        in_data   <= '0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words at the reset settings. All zeros, then all ones in
        // every field, then the saturating extremes in both directions.
        send_fields('0, '0, '0, '0, '0, '0, '0, '0, '0, 1'b0);
        send_fields('1, '1, '1, '1, '1, '1, '1, '1, '1, 1'b1);
        send_fields(VAL_MAX, VAL_MAX, VAL_MIN, VAL_MIN, '1, VAL_MIN, VAL_MAX,
                    17'd65536, 17'd65536, 1'b0);
        send_fields(VAL_MIN, VAL_MIN, VAL_MAX, VAL_MAX, '1, VAL_MIN, VAL_MAX,
                    '1, '1, 1'b1);
        // A zero speed limit forces the new velocity to zero.
        send_fields(ONE, VAL_MAX, 3 * ONE, -3 * ONE, '0, -100 * ONE, 100 * ONE,
                    17'd40000, 17'd20000, 1'b0);
        // Velocity clamped to the limit from above and from below.
        send_fields('0, 100 * ONE, 50 * ONE, 20 * ONE, LIM_W'(ONE), -1000 * ONE, 1000 * ONE,
                    17'd30000, 17'd50000, 1'b0);
        send_fields('0, -100 * ONE, -50 * ONE, -20 * ONE, LIM_W'(ONE), -1000 * ONE, 1000 * ONE,
                    17'd30000, 17'd50000, 1'b0);
        // Position pushed past the upper bound, then past the lower bound.
        send_fields(10 * ONE, 5 * ONE, 10 * ONE, 10 * ONE, LIM_W'(100 * ONE),
                    -12 * ONE, 12 * ONE, 17'd0, 17'd0, 1'b0);
        send_fields(-10 * ONE, -5 * ONE, -10 * ONE, -10 * ONE, LIM_W'(100 * ONE),
                    -12 * ONE, 12 * ONE, 17'd0, 17'd0, 1'b0);
        // Crossed bounds: the lower bound wins.
        send_fields(ONE, ONE, ONE, ONE, LIM_W'(10 * ONE), 5 * ONE, -5 * ONE,
                    17'd1000, 17'd1000, 1'b0);
        // Position saturates at the top of the range before the bound check.
        send_fields(VAL_MAX, 1000 * ONE, VAL_MAX, VAL_MAX, '1, VAL_MIN, VAL_MAX,
                    17'd0, 17'd0, 1'b0);
        // A tiny negative product must round toward minus infinity.
        send_fields('0, -40'sd1, '0, '0, LIM_W'(10 * ONE), -10 * ONE, 10 * ONE,
                    17'd0, 17'd0, 1'b0);
        send_fields(ONE, -40'sd3, ONE - 1, ONE + 1, LIM_W'(10 * ONE), -10 * ONE, 10 * ONE,
                    17'd65535, 17'd1, 1'b0);
        // Back-to-back last dimensions: each word uses the inertia from
        // before its own decay, so the velocity term shrinks word by word.
        repeat (4)
            send_fields('0, 200 * ONE, '0, '0, '1, VAL_MIN, VAL_MAX, 17'd0, 17'd0, 1'b1);
        drain();

        run_swarm(230, 1'b0);

        // Full inertia, no floor, and a step larger than the inertia so it
        // underflows to zero after the first particle. No personal pull.
        set_reg(REG_INERTIA_START, 19'd65536);
        set_reg(REG_INERTIA_FLOOR, 19'd0);
        set_reg(REG_INERTIA_STEP, 19'd131071);
        set_reg(REG_COGNITIVE_GAIN, 19'd0);
        set_reg(REG_SOCIAL_GAIN, 19'd262144);
        end_writes();
        run_swarm(130, 1'b0);

        // Start, floor and cognitive gain at their top bits, step and social gain at zero; the
        // upper data bits of the 17-bit registers are dropped. A floor equal to the inertia stops decay.
        // The receiver holds off at the start to back the block up.
        set_reg(REG_INERTIA_START, '1);
        set_reg(REG_INERTIA_FLOOR, '1);
        set_reg(REG_INERTIA_STEP, 19'd0);
        set_reg(REG_COGNITIVE_GAIN, '1);
        set_reg(REG_SOCIAL_GAIN, 19'd0);
        end_writes();
        run_swarm(150, 1'b1);

        // Zero inertia and the smallest nonzero gains.
        set_reg(REG_INERTIA_START, 19'd0);
        set_reg(REG_INERTIA_FLOOR, 19'd0);
        set_reg(REG_INERTIA_STEP, 19'd1);
        set_reg(REG_COGNITIVE_GAIN, 19'd1);
        set_reg(REG_SOCIAL_GAIN, 19'd1);
        end_writes();
        run_swarm(100, 1'b0);

        // Random settings, with a write to an empty index that must be ignored.
        set_reg(REG_INERTIA_FLOOR, CFG_DATA_W'($urandom_range(0, 65536)));
        set_reg(REG_INERTIA_STEP, CFG_DATA_W'($urandom_range(0, 4000)));
        set_reg(REG_COGNITIVE_GAIN, CFG_DATA_W'($urandom_range(0, 262144)));
        set_reg(REG_SOCIAL_GAIN, CFG_DATA_W'($urandom_range(0, 262144)));
        set_reg(REG_INERTIA_START, CFG_DATA_W'($urandom_range(0, 65536)));
        set_reg(REG_UNUSED, CFG_DATA_W'($urandom));
        end_writes();
        run_swarm(150, 1'b1);

        // Final stretch: back to the reset settings with no idling at all.
        calm = 1'b1;
        set_reg(REG_INERTIA_START, CFG_DATA_W'(INERTIA_START_RST));
        set_reg(REG_INERTIA_FLOOR, CFG_DATA_W'(INERTIA_FLOOR_RST));
        set_reg(REG_INERTIA_STEP, CFG_DATA_W'(INERTIA_STEP_RST));
        set_reg(REG_COGNITIVE_GAIN, COGNITIVE_GAIN_RST);
        set_reg(REG_SOCIAL_GAIN, SOCIAL_GAIN_RST);
        end_writes();
        run_swarm(170, 1'b0);

        // Everything predicted has come out; give a stray word time to show.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Watchdog: a correct run ends well before this limit, even with every stall at its longest.
    initial
    begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

/* sim.f */
design/psovu_pkg.sv
design/psovu_mac.sv
design/pso_particle_velocity_update.sv
dv/psovu_motion_check.sv
dv/tb.sv
